[sv/lhsa_pkg.sv]
// ----------------------------------------------------------------------------
// lhsa_pkg
// Shared types, color conversion constants and fixed-point helpers for the
// luma highlight / shadow adjustment pipeline.
// ----------------------------------------------------------------------------
package lhsa_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type  pix;
      logic [7:0] cr;
      logic [7:0] cb;
   } chroma_type;

   localparam int PROD_W = 25;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHADOW_AMOUNT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHADOW_WIDTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHLIGHT_AMOUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHLIGHT_WIDTH  = 3'd3;

   localparam logic [7:0] PIX_MAX = 8'd255;

   localparam logic [13:0] Y_R_COEF = 14'd4899;
   localparam logic [13:0] Y_G_COEF = 14'd9617;
   localparam logic [13:0] Y_B_COEF = 14'd1868;

   localparam logic signed [15:0] CR_COEF   = 16'sd11682;
   localparam logic signed [15:0] CB_COEF   = 16'sd9241;
   localparam logic signed [15:0] B_CB_COEF = 16'sd29049;
   localparam logic signed [15:0] G_CB_COEF = -16'sd5636;
   localparam logic signed [15:0] G_CR_COEF = -16'sd11698;
   localparam logic signed [15:0] R_CR_COEF = 16'sd22987;

   localparam prod_type CHROMA_OFS = 25'sd2097152;
   localparam prod_type HALF_LSB   = 25'sd8192;

   // Rounds a 14-bit fraction away, floor after adding one half.
   function automatic logic signed [10:0] descale14(input prod_type x);
      prod_type t;
      t = x + HALF_LSB;
      return t[24:14];
   endfunction

   function automatic logic [7:0] sat8(input logic signed [11:0] x);
      logic [7:0] r;
      if (x[11]) begin
         r = 8'd0;
      end else if (x > 12'sd255) begin
         r = PIX_MAX;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

endpackage

[sv/lhsa_ycc_fwd.sv]
// ----------------------------------------------------------------------------
// lhsa_ycc_fwd
// Forward BGR to YCrCb conversion over two stages: luma first, then the two
// offset and saturated chroma terms.
// ----------------------------------------------------------------------------
module lhsa_ycc_fwd (
   input  logic                 clock,
   input  logic                 enable,
   input  lhsa_pkg::pixel_type  pix_in,
   output logic [7:0]           y_s1,
   output lhsa_pkg::chroma_type chroma_s2
);
   import lhsa_pkg::*;

   logic [21:0] y_sum;
   logic [7:0]  y_in;
   logic [7:0]  y_ff;
   pixel_type   pix_ff;

   logic signed [8:0] dr;
   logic signed [8:0] db;
   prod_type          cr_prod;
   prod_type          cb_prod;
   chroma_type        chroma_in;
   chroma_type        chroma_ff;

   always_comb begin
      y_sum = 22'(pix_in.red) * 22'(Y_R_COEF) + 22'(pix_in.green) * 22'(Y_G_COEF)
            + 22'(pix_in.blue) * 22'(Y_B_COEF) + 22'(HALF_LSB);
      y_in  = y_sum[21:14];
   end

   always_comb begin
      dr      = $signed({1'b0, pix_ff.red}) - $signed({1'b0, y_ff});
      db      = $signed({1'b0, pix_ff.blue}) - $signed({1'b0, y_ff});
      cr_prod = PROD_W'(dr) * PROD_W'(CR_COEF) + CHROMA_OFS;
      cb_prod = PROD_W'(db) * PROD_W'(CB_COEF) + CHROMA_OFS;
      chroma_in.pix = pix_ff;
      chroma_in.cr  = sat8(12'(descale14(cr_prod)));
      chroma_in.cb  = sat8(12'(descale14(cb_prod)));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         y_ff      <= y_in;
         pix_ff    <= pix_in;
         chroma_ff <= chroma_in;
      end
   end

   assign y_s1      = y_ff;
   assign chroma_s2 = chroma_ff;

endmodule

[sv/lhsa_luma_curve.sv]
// ----------------------------------------------------------------------------
// lhsa_luma_curve
// Shadow / highlight tone curve on luma in three stages: region select and
// distance, gain multiply, then exact add, round half to even and clamp.
// ----------------------------------------------------------------------------
module lhsa_luma_curve #(
   parameter  int GAIN_FRAC_BITS = 8,
   localparam int WIDTH_W = (GAIN_FRAC_BITS + 1 > 9) ? GAIN_FRAC_BITS + 1 : 9
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [7:0]                y_in,
   input  logic signed [9:0]         shadow_amount,
   input  logic [WIDTH_W-1:0]        shadow_width,
   input  logic signed [9:0]         highlight_amount,
   input  logic [WIDTH_W-1:0]        highlight_width,
   output logic [7:0]                y_adj
);
   import lhsa_pkg::*;

   localparam int FB2    = 2 * GAIN_FRAC_BITS;
   localparam int DIST_W = 8 + WIDTH_W + 3;
   localparam int MUL_W  = DIST_W + 10;
   localparam int SUM_W  = ((MUL_W > 8 + FB2) ? MUL_W : 8 + FB2) + 1;
   localparam int QUO_W  = SUM_W - FB2;

   logic signed [DIST_W-1:0] ys;
   logic signed [DIST_W-1:0] sc;
   logic signed [DIST_W-1:0] hc;
   logic signed [DIST_W-1:0] sdiff;
   logic signed [DIST_W-1:0] hdiff;
   logic signed [DIST_W-1:0] dist_in;
   logic signed [9:0]        gain_in;
   logic signed [DIST_W-1:0] dist_ff;
   logic signed [9:0]        gain_ff;
   logic [7:0]               y2_ff;

   logic signed [MUL_W-1:0]  prod_in;
   logic signed [MUL_W-1:0]  prod_ff;
   logic [7:0]               y3_ff;

   logic signed [SUM_W-1:0]  v_prod;
   logic signed [SUM_W-1:0]  v_base;
   logic signed [SUM_W-1:0]  v_sum;
   logic signed [QUO_W-1:0]  quo;
   logic signed [QUO_W-1:0]  quo_rnd;
   logic                     round_up;
   logic [7:0]               yadj_in;
   logic [7:0]               yadj_ff;

   always_comb begin
      ys    = DIST_W'(y_in) << GAIN_FRAC_BITS;
      sc    = DIST_W'(shadow_width) * DIST_W'(PIX_MAX);
      hc    = (DIST_W'(PIX_MAX) << GAIN_FRAC_BITS)
            - DIST_W'(highlight_width) * DIST_W'(PIX_MAX);
      sdiff = sc - ys;
      hdiff = ys - hc;
      if (!sdiff[DIST_W-1] && (sdiff != '0)) begin
         dist_in = sdiff;
         gain_in = shadow_amount;
      end else if (!hdiff[DIST_W-1] && (hdiff != '0)) begin
         dist_in = hdiff;
         gain_in = highlight_amount;
      end else begin
         dist_in = '0;
         gain_in = '0;
      end
   end

   assign prod_in = MUL_W'(dist_ff) * MUL_W'(gain_ff);

   always_comb begin
      v_prod   = SUM_W'(prod_ff);
      v_base   = SUM_W'(y3_ff) << FB2;
      v_sum    = v_prod + v_base;
      quo      = v_sum[SUM_W-1:FB2];
      round_up = v_sum[FB2-1] && ((|v_sum[FB2-2:0]) || quo[0]);
      quo_rnd  = quo + QUO_W'(round_up);
      if (quo_rnd[QUO_W-1]) begin
         yadj_in = 8'd0;
      end else if (quo_rnd > QUO_W'(PIX_MAX)) begin
         yadj_in = PIX_MAX;
      end else begin
         yadj_in = quo_rnd[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dist_ff <= dist_in;
         gain_ff <= gain_in;
         y2_ff   <= y_in;
         prod_ff <= prod_in;
         y3_ff   <= y2_ff;
         yadj_ff <= yadj_in;
      end
   end

   assign y_adj = yadj_ff;

endmodule

[sv/lhsa_ycc_inv.sv]
// ----------------------------------------------------------------------------
// lhsa_ycc_inv
// YCrCb to BGR conversion with saturation, registered as the output stage,
// with the untouched pixel selected when both gains are zero.
// ----------------------------------------------------------------------------
module lhsa_ycc_inv (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [7:0]           y_adj,
   input  lhsa_pkg::chroma_type chroma,
   input  logic                 bypass,
   output lhsa_pkg::pixel_type  pix_out,
   output logic                 changed
);
   import lhsa_pkg::*;

   logic signed [8:0]  dcr;
   logic signed [8:0]  dcb;
   logic signed [10:0] b_d;
   logic signed [10:0] g_d;
   logic signed [10:0] r_d;
   logic signed [11:0] ys;
   pixel_type          pix_in;
   logic               changed_in;
   pixel_type          pix_ff;
   logic               changed_ff;

   always_comb begin
      dcr = $signed({1'b0, chroma.cr}) - 9'sd128;
      dcb = $signed({1'b0, chroma.cb}) - 9'sd128;
      b_d = descale14(PROD_W'(dcb) * PROD_W'(B_CB_COEF));
      g_d = descale14(PROD_W'(dcb) * PROD_W'(G_CB_COEF) + PROD_W'(dcr) * PROD_W'(G_CR_COEF));
      r_d = descale14(PROD_W'(dcr) * PROD_W'(R_CR_COEF));
      ys  = $signed({4'b0, y_adj});
      if (bypass) begin
         pix_in     = chroma.pix;
         changed_in = 1'b0;
      end else begin
         pix_in.blue  = sat8(ys + 12'(b_d));
         pix_in.green = sat8(ys + 12'(g_d));
         pix_in.red   = sat8(ys + 12'(r_d));
         changed_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pix_ff     <= pix_in;
         changed_ff <= changed_in;
      end
   end

   assign pix_out = pix_ff;
   assign changed = changed_ff;

endmodule

[sv/luma_highlight_shadow_adjust_core.sv]
// ----------------------------------------------------------------------------
// luma_highlight_shadow_adjust_core
// Shadow / highlight luma adjustment of a BGR pixel stream in YCrCb space.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock while no result waits on rsp_tready.
// Luma owns the first register stage, chroma and the curve distance share
// the second, and the gain multiply, the rounding and the back conversion
// each own one of the last three. The whole pipeline advances together and
// holds in place while a result waits on rsp_tready, so req_tready follows
// the output side. Write the configuration registers only while no item is
// in flight.
module luma_highlight_shadow_adjust_core #(
   parameter  int GAIN_FRAC_BITS = 8,
   localparam int WIDTH_W = (GAIN_FRAC_BITS + 1 > 9) ? GAIN_FRAC_BITS + 1 : 9
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // blue_in, green_in, red_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,  // blue_out, green_out, red_out
   output logic                                 rsp_tuser,  // changed
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lhsa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lhsa_pkg::CSR_DATA_W-1:0]      csr_data
);
   import lhsa_pkg::*;

   localparam int STAGES = 5;

   logic signed [9:0]    shadow_amount_ff, shadow_amount_in;
   logic [WIDTH_W-1:0]   shadow_width_ff, shadow_width_in;
   logic signed [9:0]    highlight_amount_ff, highlight_amount_in;
   logic [WIDTH_W-1:0]   highlight_width_ff, highlight_width_in;

   logic [STAGES-1:0]    valid_ff, valid_in;
   logic                 pipe_en;
   logic                 bypass;

   pixel_type            req_pix;
   pixel_type            rsp_pix;
   logic [7:0]           y_s1;
   logic [7:0]           y_adj;
   chroma_type           chroma_s2;
   chroma_type           chroma3_ff;
   chroma_type           chroma4_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      shadow_amount_in    = shadow_amount_ff;
      shadow_width_in     = shadow_width_ff;
      highlight_amount_in = highlight_amount_ff;
      highlight_width_in  = highlight_width_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHADOW_AMOUNT:    shadow_amount_in    = $signed(csr_data[9:0]);
            CSR_SHADOW_WIDTH:     shadow_width_in     = WIDTH_W'(csr_data[8:0]);
            CSR_HIGHLIGHT_AMOUNT: highlight_amount_in = $signed(csr_data[9:0]);
            CSR_HIGHLIGHT_WIDTH:  highlight_width_in  = WIDTH_W'(csr_data[8:0]);
            default: ;
         endcase
      end
   end

   assign pipe_en    = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = pipe_en;
   assign valid_in   = {valid_ff[STAGES-2:0], req_tvalid};
   assign bypass     = (shadow_amount_ff == '0) && (highlight_amount_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_amount_ff    <= '0;
         shadow_width_ff     <= WIDTH_W'(1 << GAIN_FRAC_BITS);
         highlight_amount_ff <= '0;
         highlight_width_ff  <= WIDTH_W'(1 << GAIN_FRAC_BITS);
         valid_ff            <= '0;
      end else begin
         shadow_amount_ff    <= shadow_amount_in;
         shadow_width_ff     <= shadow_width_in;
         highlight_amount_ff <= highlight_amount_in;
         highlight_width_ff  <= highlight_width_in;
         if (pipe_en) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         chroma3_ff <= chroma_s2;
         chroma4_ff <= chroma3_ff;
      end
   end

   assign req_pix = req_tdata;

   lhsa_ycc_fwd u_fwd (
      .clock     (clock),
      .enable    (pipe_en),
      .pix_in    (req_pix),
      .y_s1      (y_s1),
      .chroma_s2 (chroma_s2)
   );

   lhsa_luma_curve #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_curve (
      .clock            (clock),
      .enable           (pipe_en),
      .y_in             (y_s1),
      .shadow_amount    (shadow_amount_ff),
      .shadow_width     (shadow_width_ff),
      .highlight_amount (highlight_amount_ff),
      .highlight_width  (highlight_width_ff),
      .y_adj            (y_adj)
   );

   lhsa_ycc_inv u_inv (
      .clock   (clock),
      .enable  (pipe_en),
      .y_adj   (y_adj),
      .chroma  (chroma4_ff),
      .bypass  (bypass),
      .pix_out (rsp_pix),
      .changed (rsp_tuser)
   );

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = rsp_pix;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   a_valid_shifts: assert property (@(posedge clock) disable iff (reset)
      pipe_en && valid_ff[0] |=> valid_ff[1])
      else $error("item lost between first and second stage");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == !bypass))
      else $error("changed flag disagrees with gain configuration");

endmodule

[tb/tb_luma_highlight_shadow_adjust_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_luma_highlight_shadow_adjust_core
// Self-checking bench for the shadow / highlight luma core. Pixels are sent
// through the request stream under a range of curve settings. Each accepted
// item is run through a local model of the YCrCb round trip and luma curve.
// Every result is checked in order against that model while both sides of
// the stream idle at random.
// ----------------------------------------------------------------------------
module tb_luma_highlight_shadow_adjust_core;
   import lhsa_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = 3'd7;

   typedef struct {
      pixel_type pix;
      logic      changed;
   } adjusted_pixel_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Local copy of the curve registers, at their reset values.
   int shadow_gain    = 0;
   int shadow_span    = 256;
   int highlight_gain = 0;
   int highlight_span = 256;

   adjusted_pixel_type expected_pixels[$];
   int  mismatches       = 0;
   int  pixels_sent      = 0;
   int  pixels_checked   = 0;
   int  curve_settings   = 0;
   int  quiet_cycles     = 0;
   bit  steady_flow      = 1'b0;
   bit  hold_rsp_request = 1'b0;

   luma_highlight_shadow_adjust_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int descale_q14(input int x);
      return (x + 8192) >>> 14;
   endfunction

   function automatic int clip_to_byte(input int v);
      int r;
      r = (v < 0) ? 0 : ((v > 255) ? 255 : v);
      return r;
   endfunction

   function automatic int shape_luma(input int y);
      longint ys, sc, hc, acc, q, rem;
      ys  = longint'(y) <<< 8;
      sc  = 255 * longint'(shadow_span);
      hc  = (longint'(255) <<< 8) - 255 * longint'(highlight_span);
      acc = longint'(y) <<< 16;
      if (ys < sc) begin
         acc += (sc - ys) * longint'(shadow_gain);
      end else if (ys > hc) begin
         acc += (ys - hc) * longint'(highlight_gain);
      end
      q   = acc >>> 16;
      rem = acc - (q <<< 16);
      if (rem > 32768 || (rem == 32768 && (q & 1) != 0)) begin
         q++;
      end
      if (q < 0) begin
         q = 0;
      end else if (q > 255) begin
         q = 255;
      end
      return int'(q);
   endfunction

   function automatic adjusted_pixel_type predict_adjusted_pixel(input pixel_type px);
      adjusted_pixel_type res;
      int b, g, r, y, cr, cb, dcr, dcb;
      b = px.blue;
      g = px.green;
      r = px.red;
      res.pix = px;
      res.changed = 1'b0;
      if (shadow_gain == 0 && highlight_gain == 0) begin
         return res;
      end
      y   = descale_q14(r * 4899 + g * 9617 + b * 1868);
      cr  = clip_to_byte(descale_q14((r - y) * 11682 + (128 << 14)));
      cb  = clip_to_byte(descale_q14((b - y) * 9241 + (128 << 14)));
      y   = shape_luma(clip_to_byte(y));
      dcr = cr - 128;
      dcb = cb - 128;
      res.pix.blue  = 8'(clip_to_byte(y + descale_q14(dcb * 29049)));
      res.pix.green = 8'(clip_to_byte(y + descale_q14(dcb * (-5636) + dcr * (-11698))));
      res.pix.red   = 8'(clip_to_byte(y + descale_q14(dcr * 22987)));
      res.changed   = 1'b1;
      return res;
   endfunction

   function automatic int idle_length();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      return n;
   endfunction

   function automatic pixel_type bgr(input int b, input int g, input int r);
      pixel_type px;
      px.blue  = 8'(b);
      px.green = 8'(g);
      px.red   = 8'(r);
      return px;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int pick;
      pick = $urandom_range(0, 9);
      px.blue  = 8'($urandom_range(0, 255));
      px.green = 8'($urandom_range(0, 255));
      px.red   = 8'($urandom_range(0, 255));
      if (pick < 2) begin
         px.green = px.blue;
         px.red   = px.blue;
      end else if (pick == 2) begin
         px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return px;
   endfunction

   function automatic int random_gain();
      int v;
      v = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023))
                                      : int'($urandom_range(0, 512)) - 256;
      return v;
   endfunction

   function automatic int random_span();
      int v;
      v = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 511))
                                      : int'($urandom_range(0, 256));
      return v;
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 15) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sampled at the falling edge, where the values of the coming rising edge are settled.
   always @(negedge clock) begin
      adjusted_pixel_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result %h with no pixel outstanding", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("blue_out", want.pix.blue, got.blue);
            compare_field("green_out", want.pix.green, got.green);
            compare_field("red_out", want.pix.red, got.red);
            compare_field("changed", {7'd0, want.changed}, {7'd0, rsp_tuser});
            pixels_checked++;
         end
      end
   end

   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_pixel(input pixel_type px);
      bit taken;
      int gap;
      gap = (steady_flow || $urandom_range(0, 99) >= 30) ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      expected_pixels.push_back(predict_adjusted_pixel(px));
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      logic [CSR_DATA_W-1:0] bits;
      bit taken;
      bits = value[CSR_DATA_W-1:0];
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= bits;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      case (index)
         CSR_SHADOW_AMOUNT:    shadow_gain    = $signed(bits);
         CSR_SHADOW_WIDTH:     shadow_span    = bits[8:0];
         CSR_HIGHLIGHT_AMOUNT: highlight_gain = $signed(bits);
         CSR_HIGHLIGHT_WIDTH:  highlight_span = bits[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_curve(input int s_gain, input int s_span, input int h_gain,
                            input int h_span);
      wait_idle();
      write_reg(CSR_SHADOW_AMOUNT, s_gain);
      write_reg(CSR_SHADOW_WIDTH, s_span);
      write_reg(CSR_HIGHLIGHT_AMOUNT, h_gain);
      write_reg(CSR_HIGHLIGHT_WIDTH, h_span);
      curve_settings++;
   endtask

   task automatic test_reset_passthrough();
      send_pixel(bgr(0, 0, 0));
      send_pixel(bgr(255, 255, 255));
      send_pixel(bgr(12, 200, 77));
      send_pixel(bgr(255, 0, 128));
   endtask

   task automatic test_curve_edges();
      // Full gains: gray 0 and gray 255 sit exactly on the cutoffs.
      set_curve(256, 256, -256, 256);
      send_pixel(bgr(0, 0, 0));
      send_pixel(bgr(255, 255, 255));
      send_pixel(bgr(0, 0, 255));
      send_pixel(bgr(0, 255, 0));
      send_pixel(bgr(255, 0, 0));
      // A gain of one half lands on exact halves for even gray levels.
      set_curve(128, 256, 0, 0);
      send_pixel(bgr(100, 100, 100));
      send_pixel(bgr(101, 101, 101));
      send_pixel(bgr(102, 102, 102));
      // Registers beyond the documented range are used as written.
      set_curve(-512, 511, 511, 511);
      send_pixel(bgr(30, 30, 30));
      send_pixel(bgr(220, 220, 220));
      send_pixel(bgr(255, 0, 255));
      // Zero widths leave luma alone but the color round trip still runs.
      set_curve(0, 0, 1, 0);
      send_pixel(bgr(255, 255, 0));
      send_pixel(bgr(0, 128, 255));
      wait_idle();
      write_reg(CSR_INDEX_W'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)), 1023);
      send_pixel(bgr(10, 20, 30));
      set_curve(0, 256, 0, 256);
      send_pixel(bgr(1, 254, 127));
      send_pixel(bgr(200, 3, 99));
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_curve(256, 256, 256, 256);
            1: set_curve(-256, 256, -256, 256);
            2: set_curve(256, 0, -256, 0);
            3: set_curve(-256, 1, 256, 255);
            4: set_curve(0, random_span(), 0, random_span());
            default: set_curve(random_gain(), random_span(), random_gain(), random_span());
         endcase
         repeat (70) send_pixel(random_pixel());
      end
   endtask

   task automatic test_steady_stream();
      set_curve(random_gain(), random_span(), random_gain(), random_span());
      steady_flow = 1'b1;
      repeat (60) send_pixel(random_pixel());
      steady_flow = 1'b0;
   endtask

   task automatic test_output_backpressure();
      set_curve(random_gain(), random_span(), random_gain(), random_span());
      steady_flow = 1'b1;
      hold_rsp_request = 1'b1;
      repeat (60) send_pixel(random_pixel());
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_passthrough();
      test_curve_edges();
      test_random_settings();
      test_steady_stream();
      test_output_backpressure();
      wait_idle();
      $display("Checked %0d of %0d pixels over %0d curve settings, passthrough included.",
               pixels_checked, pixels_sent, curve_settings);
      $display("Covered out-of-range registers, an ignored register index and a long stall.");
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
sv/lhsa_pkg.sv
sv/lhsa_ycc_fwd.sv
sv/lhsa_luma_curve.sv
sv/lhsa_ycc_inv.sv
sv/luma_highlight_shadow_adjust_core.sv
tb/tb_luma_highlight_shadow_adjust_core.sv
